// ----- rtl/core/rdgs_pkg.sv -----
package rdgs_pkg;

    localparam int GridSideDef = 64;
    localparam int QueueDepth  = 2;
    localparam int AccW        = 48;
    localparam int ProdW       = 65;

    // request kinds
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_A = 3'd0;
    localparam logic [2:0] REG_COEF_B = 3'd1;
    localparam logic [2:0] REG_COEF_C = 3'd2;
    localparam logic [2:0] REG_COEF_D = 3'd3;
    localparam logic [2:0] REG_DIFF_U = 3'd4;
    localparam logic [2:0] REG_DIFF_V = 3'd5;
    localparam logic [2:0] REG_EQU_U  = 3'd6;
    localparam logic [2:0] REG_EQU_V  = 3'd7;

    localparam logic signed [31:0] RST_COEF_A = 32'sd335544;
    localparam logic signed [31:0] RST_COEF_B = -32'sd335544;
    localparam logic signed [31:0] RST_COEF_C = 32'sd671089;
    localparam logic signed [31:0] RST_COEF_D = -32'sd503316;
    localparam logic signed [31:0] RST_DIFF_U = 32'sd335544;
    localparam logic signed [31:0] RST_DIFF_V = 32'sd2013266;
    localparam logic signed [31:0] RST_EQU_U  = 32'sd16777216;
    localparam logic signed [31:0] RST_EQU_V  = 32'sd16777216;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        cell_index;
        logic signed [31:0] u_load;
        logic signed [31:0] v_load;
    } t_req;

    typedef struct packed {
        logic [11:0]        cell_out;
        logic signed [31:0] u_out;
        logic signed [31:0] v_out;
    } t_res;

    typedef struct packed {
        logic signed [31:0] coef_a_dt;
        logic signed [31:0] coef_b_dt;
        logic signed [31:0] coef_c_dt;
        logic signed [31:0] coef_d_dt;
        logic signed [31:0] diff_u;
        logic signed [31:0] diff_v;
        logic signed [31:0] equil_u;
        logic signed [31:0] equil_v;
    } t_cfg;

    // queue entry between front and back
    typedef struct packed {
        logic [1:0]         kind;
        logic               oor;
        logic [11:0]        cell_idx;
        logic signed [31:0] u_val;
        logic signed [31:0] v_val;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_head;

    // round a Q8.24 x Q8.24 product back to Q8.24, ties toward plus infinity
    function automatic logic signed [AccW-1:0] rnd_q24(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-1:0] t;
        t = p + ProdW'(64'sd8388608);
        return AccW'($signed(t[ProdW-1:24]));
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] x);
        logic signed [AccW-1:0] hi;
        logic signed [AccW-1:0] lo;
        hi = AccW'(64'sd2147483647);
        lo = -AccW'(64'sd2147483648);
        if (x > hi) begin
            return 32'sh7fffffff;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

// ----- rtl/core/reaction_diffusion_grid_step_unit.sv -----
// Reaction-diffusion grid step. Holds u and v on a GRID_SIDE x GRID_SIDE
// toroidal grid in two banks and takes three requests: load a cell, read a
// cell, advance one explicit Euler generation. A request is taken when start
// is high and busy is low; busy only means the two-entry request queue is
// full, so requests keep flowing while an advance runs. A load is written to
// its cell as it leaves the queue; a read returns its result with o_res_valid
// high for exactly one cycle, the cycle right after it leaves the queue;
// there is no way to hold a result off, so capture it on that cycle. An
// advance occupies the engine while every cell takes five single-port reads
// of each field (centre and four neighbours), four passes through one
// 32 x 33 multiplier per field and a write-back. Loads and reads queued
// behind it wait for it. Out-of-grid loads and the unused request kind are
// dropped; an out-of-grid read returns zeros.
// Write the coefficient registers only while nothing is queued or running.
module reaction_diffusion_grid_step_unit import rdgs_pkg::*; #(
    parameter int GRID_SIDE = GridSideDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_req        i_req,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_res_valid,
    output t_res        o_res
);

    t_cfg  r_cfg;
    t_head head;
    logic  pop;

    // coefficient registers: plain write, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a_dt <= RST_COEF_A;
            r_cfg.coef_b_dt <= RST_COEF_B;
            r_cfg.coef_c_dt <= RST_COEF_C;
            r_cfg.coef_d_dt <= RST_COEF_D;
            r_cfg.diff_u    <= RST_DIFF_U;
            r_cfg.diff_v    <= RST_DIFF_V;
            r_cfg.equil_u   <= RST_EQU_U;
            r_cfg.equil_v   <= RST_EQU_V;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_A: r_cfg.coef_a_dt <= i_cfg_data;
                REG_COEF_B: r_cfg.coef_b_dt <= i_cfg_data;
                REG_COEF_C: r_cfg.coef_c_dt <= i_cfg_data;
                REG_COEF_D: r_cfg.coef_d_dt <= i_cfg_data;
                REG_DIFF_U: r_cfg.diff_u    <= i_cfg_data;
                REG_DIFF_V: r_cfg.diff_v    <= i_cfg_data;
                REG_EQU_U:  r_cfg.equil_u   <= i_cfg_data;
                REG_EQU_V:  r_cfg.equil_v   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept, classify, queue
    rdgs_front #(.GRID_SIDE(GRID_SIDE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .i_pop   (pop),
        .o_head  (head)
    );

    // back: field memories, stencil sequencer, result register
    rdgs_back #(.GRID_SIDE(GRID_SIDE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

// ----- rtl/core/rdgs_front.sv -----
module rdgs_front import rdgs_pkg::*; #(
    parameter int GRID_SIDE = GridSideDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_req  i_req,
    output logic  busy,
    input  logic  i_pop,
    output t_head o_head
);

    localparam int CellCount = GRID_SIDE * GRID_SIDE;

    t_op        r_q [QueueDepth];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    logic in_rng;
    logic keep;
    logic push;
    logic pop;
    t_op  entry;

    assign in_rng = (32'(i_req.cell_index) < 32'(CellCount));
    assign busy   = (r_cnt == 2'(QueueDepth));

    // classify: drop unused kinds and out-of-grid loads here
    always_comb begin
        unique case (i_req.kind)
            KIND_LOAD:    keep = in_rng;
            KIND_ADVANCE: keep = 1'b1;
            KIND_READ:    keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    always_comb begin
        entry.kind     = i_req.kind;
        entry.oor      = !in_rng;
        entry.cell_idx = i_req.cell_index;
        entry.u_val    = i_req.u_load;
        entry.v_val    = i_req.v_load;
    end

    assign push = start && !busy && keep;
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= entry;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.op    = r_q[r_rp];

endmodule

// ----- rtl/core/rdgs_back.sv -----
module rdgs_back import rdgs_pkg::*; #(
    parameter int GRID_SIDE = GridSideDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_head i_head,
    output logic  o_pop,
    output logic  o_res_valid,
    output t_res  o_res
);

    localparam int CellCount = GRID_SIDE * GRID_SIDE;
    localparam int IW        = $clog2(CellCount);
    localparam int AW        = $clog2(2 * CellCount);
    localparam int RW        = $clog2(GRID_SIDE);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [3:0] STEP_CEN   = 4'd0;
    localparam logic [3:0] STEP_UP    = 4'd1;
    localparam logic [3:0] STEP_DOWN  = 4'd2;
    localparam logic [3:0] STEP_LEFT  = 4'd3;
    localparam logic [3:0] STEP_RIGHT = 4'd4;
    localparam logic [3:0] STEP_LAST  = 4'd5;
    localparam logic [3:0] STEP_MA    = 4'd6;
    localparam logic [3:0] STEP_MB    = 4'd7;
    localparam logic [3:0] STEP_MLO   = 4'd8;
    localparam logic [3:0] STEP_MHI   = 4'd9;
    localparam logic [3:0] STEP_SUM   = 4'd10;
    localparam logic [3:0] STEP_WR    = 4'd11;

    logic signed [31:0] mem_u [2 * CellCount];
    logic signed [31:0] mem_v [2 * CellCount];

    logic               r_state;
    logic [3:0]         r_step;
    logic               r_bank;
    logic [IW-1:0]      r_idx;
    logic [RW-1:0]      r_row;
    logic [RW-1:0]      r_col;
    logic signed [31:0] r_rdu, r_rdv;
    logic signed [31:0] r_cen_u, r_cen_v;
    logic signed [33:0] r_nsum_u, r_nsum_v;
    logic signed [34:0] r_lap_u, r_lap_v;
    logic signed [ProdW-1:0] r_prod_u, r_prod_v;
    logic signed [AccW-1:0]  r_acc_u, r_acc_v;
    logic               r_pend;
    logic               r_oor;
    logic [11:0]        r_cell;

    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdu, wdv;
    logic [AW-1:0]      raddr;
    logic [IW-1:0]      nb_idx;
    logic               last_cell;
    logic signed [32:0] dev_u, dev_v;
    logic signed [31:0] mcoef_u, mcoef_v;
    logic signed [32:0] mopnd_u, mopnd_v;
    logic               take;

    function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [IW-1:0] idx);
        return bank ? AW'(idx) + AW'(CellCount) : AW'(idx);
    endfunction

    assign take  = (r_state == ST_IDLE) && i_head.valid;
    assign o_pop = take;

    // neighbour address with toroidal wrap
    always_comb begin
        unique case (r_step)
            STEP_UP:    nb_idx = (r_row == '0) ? r_idx + IW'(CellCount - GRID_SIDE)
                                               : r_idx - IW'(GRID_SIDE);
            STEP_DOWN:  nb_idx = (r_row == RW'(GRID_SIDE - 1))
                                 ? r_idx - IW'(CellCount - GRID_SIDE) : r_idx + IW'(GRID_SIDE);
            STEP_LEFT:  nb_idx = (r_col == '0) ? r_idx + IW'(GRID_SIDE - 1) : r_idx - IW'(1);
            STEP_RIGHT: nb_idx = (r_col == RW'(GRID_SIDE - 1))
                                 ? r_idx - IW'(GRID_SIDE - 1) : r_idx + IW'(1);
            default:    nb_idx = r_idx;
        endcase
    end

    assign last_cell = (r_idx == IW'(CellCount - 1));

    always_comb begin
        if (r_state == ST_RUN) begin
            raddr = bank_addr(r_bank, nb_idx);
        end else begin
            raddr = bank_addr(r_bank, IW'(i_head.op.cell_idx));
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = bank_addr(r_bank, IW'(i_head.op.cell_idx));
        wdu   = i_head.op.u_val;
        wdv   = i_head.op.v_val;
        if (r_state == ST_RUN) begin
            we    = (r_step == STEP_WR);
            waddr = bank_addr(~r_bank, r_idx);
            wdu   = sat32(r_acc_u);
            wdv   = sat32(r_acc_v);
        end else if (take && i_head.op.kind == KIND_LOAD) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_u[waddr] <= wdu;
            mem_v[waddr] <= wdv;
        end
        r_rdu <= mem_u[raddr];
        r_rdv <= mem_v[raddr];
    end

    assign dev_u = 33'(r_cen_u) - 33'(i_cfg.equil_u);
    assign dev_v = 33'(r_cen_v) - 33'(i_cfg.equil_v);

    // one multiplier per field, operands chosen by the step
    always_comb begin
        case (r_step)
            STEP_MA: begin
                mcoef_u = i_cfg.coef_a_dt;  mopnd_u = dev_u;
                mcoef_v = i_cfg.coef_c_dt;  mopnd_v = dev_u;
            end
            STEP_MB: begin
                mcoef_u = i_cfg.coef_b_dt;  mopnd_u = dev_v;
                mcoef_v = i_cfg.coef_d_dt;  mopnd_v = dev_v;
            end
            STEP_MLO: begin
                mcoef_u = i_cfg.diff_u;     mopnd_u = $signed({9'b0, r_lap_u[23:0]});
                mcoef_v = i_cfg.diff_v;     mopnd_v = $signed({9'b0, r_lap_v[23:0]});
            end
            default: begin
                mcoef_u = i_cfg.diff_u;     mopnd_u = 33'($signed(r_lap_u[34:24]));
                mcoef_v = i_cfg.diff_v;     mopnd_v = 33'($signed(r_lap_v[34:24]));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod_u <= ProdW'(mcoef_u) * ProdW'(mopnd_u);
        r_prod_v <= ProdW'(mcoef_v) * ProdW'(mopnd_v);
        case (r_step)
            STEP_UP: begin
                r_cen_u <= r_rdu;
                r_cen_v <= r_rdv;
            end
            STEP_DOWN: begin
                r_nsum_u <= 34'(r_rdu);
                r_nsum_v <= 34'(r_rdv);
            end
            STEP_LEFT, STEP_RIGHT, STEP_LAST: begin
                r_nsum_u <= r_nsum_u + 34'(r_rdu);
                r_nsum_v <= r_nsum_v + 34'(r_rdv);
            end
            STEP_MA: begin
                r_lap_u <= 35'(r_nsum_u) - (35'(r_cen_u) <<< 2);
                r_lap_v <= 35'(r_nsum_v) - (35'(r_cen_v) <<< 2);
                r_acc_u <= AccW'(r_cen_u);
                r_acc_v <= AccW'(r_cen_v);
            end
            STEP_MB, STEP_MLO, STEP_MHI: begin
                r_acc_u <= r_acc_u + rnd_q24(r_prod_u);
                r_acc_v <= r_acc_v + rnd_q24(r_prod_v);
            end
            STEP_SUM: begin
                // high half of the Laplacian product is already whole units
                r_acc_u <= r_acc_u + AccW'(r_prod_u);
                r_acc_v <= r_acc_v + AccW'(r_prod_v);
            end
            default: ;
        endcase
        r_cell <= i_head.op.cell_idx;
        r_oor  <= i_head.op.oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_CEN;
            r_bank  <= 1'b0;
            r_idx   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= take && (i_head.op.kind == KIND_READ);
            unique case (r_state)
                ST_IDLE: begin
                    if (take && i_head.op.kind == KIND_ADVANCE) begin
                        r_state <= ST_RUN;
                        r_step  <= STEP_CEN;
                        r_idx   <= '0;
                        r_row   <= '0;
                        r_col   <= '0;
                    end
                end
                ST_RUN: begin
                    if (r_step == STEP_WR) begin
                        r_step <= STEP_CEN;
                        r_idx  <= r_idx + IW'(1);
                        if (r_col == RW'(GRID_SIDE - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + RW'(1);
                        end else begin
                            r_col <= r_col + RW'(1);
                        end
                        if (last_cell) begin
                            r_state <= ST_IDLE;
                            r_bank  <= ~r_bank;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid    = r_pend;
    assign o_res.cell_out = r_cell;
    assign o_res.u_out    = r_oor ? 32'sd0 : r_rdu;
    assign o_res.v_out    = r_oor ? 32'sd0 : r_rdv;

endmodule

// ----- rtl/core/rdgs_chk.sv -----
module rdgs_chk import rdgs_pkg::*; #(
    parameter int GRID_SIDE = GridSideDef
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_res_valid,
    input t_res        o_res
);

    localparam int CellCount = GRID_SIDE * GRID_SIDE;

    a_rst_res: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result strobe after reset");

    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy after reset");

    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("queue filled without a request");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (32'(o_res.cell_out) >= 32'(CellCount)))
            |-> (o_res.u_out == 32'sd0 && o_res.v_out == 32'sd0))
        else $error("out-of-grid read returned data");

endmodule

bind reaction_diffusion_grid_step_unit rdgs_chk #(.GRID_SIDE(GRID_SIDE)) u_rdgs_chk (.*);
